// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/ltok_pkg.sv =====
`timescale 1ns / 1ps
package ltok_pkg;
	localparam int MaxRes = 4;
	localparam logic [30:0] IntMax = 31'h7FFF_FFFF;

	typedef enum logic [13:0] {
		M_IDLE    = 14'h0001,
		M_STR     = 14'h0002,
		M_ESC     = 14'h0004,
		M_OPHOLD  = 14'h0008,
		M_INT     = 14'h0010,
		M_INTDOT  = 14'h0020,
		M_FRAC    = 14'h0040,
		M_EXPMARK = 14'h0080,
		M_EXPSIGN = 14'h0100,
		M_EXPDIG  = 14'h0200,
		M_ID      = 14'h0400,
		M_IDDOT   = 14'h0800,
		M_ID2     = 14'h1000,
		M_COMMENT = 14'h2000
	} mode_t;

	localparam logic [2:0] K_STR = 3'd0, K_OP = 3'd1, K_INT = 3'd2, K_FLT = 3'd3,
		K_BOOL = 3'd4, K_ID = 3'd5;
	localparam logic [2:0] E_OK = 3'd0, E_UNTERM = 3'd1, E_ESC = 3'd2, E_RANGE = 3'd3,
		E_FLOAT = 3'd4, E_CHAR = 3'd5;

	typedef struct packed {
		logic       char_valid;
		logic [7:0] out_char;
		logic       token_first;
		logic       token_end;
		logic [2:0] kind;
		logic [30:0] value;
		logic       line_done;
		logic [2:0] line_error;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [2:0] n;
		res_t [MaxRes-1:0] r;
	} batch_t;
endpackage

// ===== hw/rtl/line_tokenizer_stream.sv =====
`timescale 1ns / 1ps
// Streaming line tokenizer.
// Input channel in_valid/in_stall carries one source byte per item (ch, has_char,
// line_end). Output channel out_valid/out_stall carries one result per item:
// token characters with first/end marks, the kind and value at a token's end, and
// line_done with line_error on the last result of a line.
// An input item is scanned in the cycle it is accepted and yields up to four results
// as one batch, held in a two-batch queue. Results then leave one per cycle while
// out_stall is low; a batch is registered in the queue before its first result shows.
// Throughput is one item per cycle while each item gives at most one result and the
// receiver does not stall; an item giving several results holds the output for each
// of them in turn, while the queue lets the scanner take further items meanwhile.
// When the receiver stalls, results hold and the queue fills; in_stall rises once
// two batches wait. Reset empties the queue and returns the scanner to the idle
// state between tokens with no line error pending.
module line_tokenizer_stream import ltok_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic [7:0] ch,
	input  logic has_char,
	input  logic line_end,
	output logic out_valid,
	input  logic out_stall,
	output logic char_valid,
	output logic [7:0] out_char,
	output logic token_first,
	output logic token_end,
	output logic [2:0] kind,
	output logic [30:0] value,
	output logic line_done,
	output logic [2:0] line_error,
	output logic last
);
	logic b_valid, b_full;
	batch_t b_data;
	res_t r;

	ltok_front u_front (.clk, .arst_n, .ch, .has_char, .line_end, .valid(in_valid),
		.stall(in_stall), .b_valid, .b_data, .b_full);
	ltok_back u_back (.clk, .arst_n, .b_valid, .b_data, .b_full, .valid(out_valid),
		.stall(out_stall), .res(r));

	assign char_valid = r.char_valid;
	assign out_char = r.out_char;
	assign token_first = r.token_first;
	assign token_end = r.token_end;
	assign kind = r.kind;
	assign value = r.value;
	assign line_done = r.line_done;
	assign line_error = r.line_error;
	assign last = r.last;
endmodule

// ===== hw/rtl/ltok_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ltok_front import ltok_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] ch,
	input  logic has_char,
	input  logic line_end,
	input  logic valid,
	output logic stall,
	output logic b_valid,
	output batch_t b_data,
	input  logic b_full
);
	// The scan state advances by one item per cycle unless the queue is full.
	mode_t mode_q;
	logic [7:0] held_q;
	logic [30:0] acc_q;
	logic ovf_q, tokh_q, fnz_q, eneg_q, pesc_q;
	logic [3:0] wm_q;
	logic [2:0] fail_q;
	logic [9:0] sig_q, fz_q;
	logic [16:0] em_q;

	mode_t mode_d;
	logic [7:0] held_d;
	logic [30:0] acc_d;
	logic ovf_d, tokh_d, fnz_d, eneg_d, pesc_d;
	logic [3:0] wm_d;
	logic [2:0] fail_d;
	logic [9:0] sig_d, fz_d;
	logic [16:0] em_d;
	batch_t bo;
	logic go;

	assign stall = b_full;
	assign go = valid && !b_full;

	function automatic logic isd(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction
	function automatic logic isa(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction
	function automatic logic sop(logic [7:0] h);
		return h == "=" || h == "<" || h == ">" || h == "-" || h == "/";
	endfunction
	function automatic logic [3:0] wmn(logic [3:0] m, logic [7:0] c);
		logic [7:0] e;
		case (m)
			4'd1: e = "r"; 4'd2: e = "u"; 4'd3: e = "e"; 4'd5: e = "a";
			4'd6: e = "l"; 4'd7: e = "s"; 4'd8: e = "e"; default: e = 8'd0;
		endcase
		if (m == 4'd0) return c == "t" ? 4'd1 : (c == "f" ? 4'd5 : 4'd15);
		if (e != 8'd0 && c == e) return m + 4'd1;
		return 4'd15;
	endfunction

	always_comb begin
		logic [7:0] c, h;
		logic [34:0] v;
		logic [20:0] en;
		logic signed [18:0] e;
		logic bad;
		c = ch; h = held_q;
		mode_d = mode_q; held_d = held_q; acc_d = acc_q; ovf_d = ovf_q; tokh_d = tokh_q;
		fnz_d = fnz_q; eneg_d = eneg_q; pesc_d = pesc_q; wm_d = wm_q; fail_d = fail_q;
		sig_d = sig_q; fz_d = fz_q; em_d = em_q;
		bo = '0;
		v = '0; en = '0; e = '0; bad = 1'b0;

		if (has_char && fail_q == E_OK) begin
			unique case (mode_q)
				M_STR: begin
					if (c == "\\") mode_d = M_ESC;
					else if (c == "\"") begin
						if (pesc_q) begin fail_d = E_ESC; mode_d = M_IDLE; end
						else begin
							bo.r[bo.n[1:0]] = '{1'b0, 8'd0, !tokh_d, 1'b1, K_STR, 31'd0,
								1'b0, E_OK, 1'b0};
							bo.n = bo.n + 3'd1; mode_d = M_IDLE;
						end
					end else begin
						bo.r[bo.n[1:0]] = '{1'b1, c, !tokh_d, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
						bo.n = bo.n + 3'd1; tokh_d = 1'b1;
					end
				end
				M_ESC: begin
					logic [7:0] d; logic ok;
					ok = 1'b1;
					case (c)
						"n": d = 8'd10; "t": d = 8'd9; "r": d = 8'd13; "0": d = 8'd0;
						"\\", "\"", "'": d = c;
						default: begin d = 8'd0; ok = 1'b0; end
					endcase
					if (!ok) pesc_d = 1'b1;
					else begin
						bo.r[bo.n[1:0]] = '{1'b1, d, !tokh_d, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
						bo.n = bo.n + 3'd1; tokh_d = 1'b1;
					end
					mode_d = M_STR;
				end
				default: begin
					// Two passes: first the current mode's handling, then an optional restart.
					logic restart;
					restart = 1'b0;
					unique case (mode_q)
						M_OPHOLD: begin
							if (h == "/" && c == "/") mode_d = M_COMMENT;
							else if ((c == "=" && (h == "=" || h == "!" || h == "<" || h == ">"))
								|| (c == "&" && h == "&") || (c == "|" && h == "|")
								|| (c == ">" && h == "-")) begin
								bo.r[0] = '{1'b1, h, 1'b1, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.r[1] = '{1'b1, c, 1'b0, 1'b1, K_OP, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd2; mode_d = M_IDLE;
							end else if (!sop(h)) begin fail_d = E_CHAR; mode_d = M_IDLE; end
							else begin
								bo.r[0] = '{1'b1, h, 1'b1, 1'b1, K_OP, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1; restart = 1'b1;
							end
						end
						M_INT: begin
							if (isd(c)) begin
								v = {4'd0, acc_q} * 35'd10 + {27'd0, c - 8'd48};
								if (v > {4'd0, IntMax}) begin v = {4'd0, IntMax}; ovf_d = 1'b1; end
								acc_d = v[30:0];
								if ((sig_q != 0 || c != "0") && sig_q < 10'd1023) sig_d = sig_q + 10'd1;
								bo.r[0] = '{1'b1, c, !tokh_q, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1; tokh_d = 1'b1;
							end else if (c == ".") mode_d = M_INTDOT;
							else if (ovf_q) begin fail_d = E_RANGE; mode_d = M_IDLE; end
							else begin
								bo.r[0] = '{1'b0, 8'd0, 1'b0, 1'b1, K_INT, acc_q, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1; restart = 1'b1;
							end
						end
						M_INTDOT: begin
							if (isd(c)) begin
								bo.r[0] = '{1'b1, ".", 1'b0, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.r[1] = '{1'b1, c, 1'b0, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd2; mode_d = M_FRAC;
								if (sig_q == 0) begin
									if (c == "0") fz_d = 10'd1; else fnz_d = 1'b1;
								end
							end else if (ovf_q) begin fail_d = E_RANGE; mode_d = M_IDLE; end
							else begin
								bo.r[0] = '{1'b0, 8'd0, 1'b0, 1'b1, K_INT, acc_q, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1; fail_d = E_CHAR; mode_d = M_IDLE;
							end
						end
						M_FRAC, M_EXPDIG: begin
							if (isd(c) && mode_q == M_FRAC) begin
								if (sig_q == 0 && !fnz_q) begin
									if (c == "0") begin if (fz_q < 10'd1023) fz_d = fz_q + 10'd1; end
									else fnz_d = 1'b1;
								end
								bo.r[0] = '{1'b1, c, 1'b0, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1;
							end else if (isd(c)) begin
								en = {4'd0, em_q} * 21'd10 + {13'd0, c - 8'd48};
								em_d = en > 21'd99999 ? 17'd99999 : en[16:0];
								bo.r[0] = '{1'b1, c, 1'b0, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1;
							end else if ((c == "e" || c == "E") && mode_q == M_FRAC) begin
								bo.r[0] = '{1'b1, c, 1'b0, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1; mode_d = M_EXPMARK;
							end else begin
								e = (sig_q != 0) ? $signed({9'd0, sig_q}) - 19'sd1
									: -$signed({9'd0, fz_q}) - 19'sd1;
								e = eneg_q ? e - $signed({2'd0, em_q}) : e + $signed({2'd0, em_q});
								bad = (sig_q != 0 || fnz_q) && (e > 19'sd308 || e < -19'sd308);
								if (bad) begin fail_d = E_FLOAT; mode_d = M_IDLE; end
								else begin
									bo.r[0] = '{1'b0, 8'd0, 1'b0, 1'b1, K_FLT, 31'd0, 1'b0, E_OK, 1'b0};
									bo.n = 3'd1; restart = 1'b1;
								end
							end
						end
						M_EXPMARK, M_EXPSIGN: begin
							if (mode_q == M_EXPMARK && (c == "+" || c == "-")) begin
								eneg_d = (c == "-");
								bo.r[0] = '{1'b1, c, 1'b0, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1; mode_d = M_EXPSIGN;
							end else if (isd(c)) begin
								en = {4'd0, em_q} * 21'd10 + {13'd0, c - 8'd48};
								em_d = en > 21'd99999 ? 17'd99999 : en[16:0];
								bo.r[0] = '{1'b1, c, 1'b0, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1; mode_d = M_EXPDIG;
							end else begin fail_d = E_FLOAT; mode_d = M_IDLE; end
						end
						M_ID, M_ID2: begin
							if (isa(c) || isd(c)) begin
								if (mode_q == M_ID) wm_d = wmn(wm_q, c);
								bo.r[0] = '{1'b1, c, 1'b0, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1;
							end else if (c == "." && mode_q == M_ID) mode_d = M_IDDOT;
							else begin
								bo.r[0] = '{1'b0, 8'd0, 1'b0, 1'b1,
									(wm_q == 4'd4 || wm_q == 4'd9) ? K_BOOL : K_ID,
									{30'd0, wm_q == 4'd4}, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1; restart = 1'b1;
							end
						end
						M_IDDOT: begin
							if (isa(c)) begin
								bo.r[0] = '{1'b1, ".", 1'b0, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.r[1] = '{1'b1, c, 1'b0, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
								bo.n = 3'd2; wm_d = 4'd15; mode_d = M_ID2;
							end else begin
								bo.r[0] = '{1'b0, 8'd0, 1'b0, 1'b1,
									(wm_q == 4'd4 || wm_q == 4'd9) ? K_BOOL : K_ID,
									{30'd0, wm_q == 4'd4}, 1'b0, E_OK, 1'b0};
								bo.n = 3'd1; fail_d = E_CHAR; mode_d = M_IDLE;
							end
						end
						M_COMMENT: ;
						default: restart = 1'b1;
					endcase
					if (restart) begin
						tokh_d = 1'b0; mode_d = M_IDLE;
						if (c == " " || c == "\t" || c == "\r" || c > 8'd127 || c == "(" ||
							c == ")" || c == ",") ;
						else if (c == "#") mode_d = M_COMMENT;
						else if (c == "\"") begin mode_d = M_STR; pesc_d = 1'b0; end
						else if (c == "!" || c == "&" || c == "|" || sop(c)) begin
							held_d = c; mode_d = M_OPHOLD;
						end else if (c == "+" || c == "*" || c == "%") begin
							bo.r[bo.n[1:0]] = '{1'b1, c, 1'b1, 1'b1, K_OP, 31'd0, 1'b0, E_OK, 1'b0};
							bo.n = bo.n + 3'd1;
						end else if (isd(c)) begin
							mode_d = M_INT; acc_d = {23'd0, c - 8'd48}; ovf_d = 1'b0;
							sig_d = {9'd0, c != "0"}; fz_d = '0; fnz_d = 1'b0; eneg_d = 1'b0;
							em_d = '0;
							bo.r[bo.n[1:0]] = '{1'b1, c, 1'b1, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
							bo.n = bo.n + 3'd1; tokh_d = 1'b1;
						end else if (isa(c)) begin
							mode_d = M_ID; wm_d = wmn(4'd0, c);
							bo.r[bo.n[1:0]] = '{1'b1, c, 1'b1, 1'b0, 3'd0, 31'd0, 1'b0, E_OK, 1'b0};
							bo.n = bo.n + 3'd1; tokh_d = 1'b1;
						end else fail_d = E_CHAR;
					end
				end
			endcase
		end

		if (line_end) begin
			if (fail_d == E_OK) begin
				unique case (mode_d)
					M_STR, M_ESC: fail_d = E_UNTERM;
					M_OPHOLD: begin
						if (sop(held_d)) begin
							bo.r[bo.n[1:0]] = '{1'b1, held_d, 1'b1, 1'b1, K_OP, 31'd0, 1'b0, E_OK, 1'b0};
							bo.n = bo.n + 3'd1;
						end else fail_d = E_CHAR;
					end
					M_INT, M_INTDOT: begin
						if (ovf_d) fail_d = E_RANGE;
						else begin
							bo.r[bo.n[1:0]] = '{1'b0, 8'd0, 1'b0, 1'b1, K_INT, acc_d, 1'b0, E_OK, 1'b0};
							bo.n = bo.n + 3'd1;
							if (mode_d == M_INTDOT) fail_d = E_CHAR;
						end
					end
					M_FRAC, M_EXPMARK, M_EXPSIGN, M_EXPDIG: begin
						e = (sig_d != 0) ? $signed({9'd0, sig_d}) - 19'sd1
							: -$signed({9'd0, fz_d}) - 19'sd1;
						e = eneg_d ? e - $signed({2'd0, em_d}) : e + $signed({2'd0, em_d});
						if (mode_d == M_EXPMARK || mode_d == M_EXPSIGN ||
							((sig_d != 0 || fnz_d) && (e > 19'sd308 || e < -19'sd308)))
							fail_d = E_FLOAT;
						else begin
							bo.r[bo.n[1:0]] = '{1'b0, 8'd0, 1'b0, 1'b1, K_FLT, 31'd0, 1'b0, E_OK, 1'b0};
							bo.n = bo.n + 3'd1;
						end
					end
					M_ID, M_ID2, M_IDDOT: begin
						bo.r[bo.n[1:0]] = '{1'b0, 8'd0, 1'b0, 1'b1,
							(wm_d == 4'd4 || wm_d == 4'd9) ? K_BOOL : K_ID,
							{30'd0, wm_d == 4'd4}, 1'b0, E_OK, 1'b0};
						bo.n = bo.n + 3'd1;
						if (mode_d == M_IDDOT) fail_d = E_CHAR;
					end
					default: ;
				endcase
			end
			if (bo.n == 3'd0) bo.n = 3'd1;
			bo.r[bo.n[1:0] - 2'd1].line_done = 1'b1;
			bo.r[bo.n[1:0] - 2'd1].line_error = fail_d;
			mode_d = M_IDLE; held_d = '0; acc_d = '0; ovf_d = 1'b0; tokh_d = 1'b0;
			fnz_d = 1'b0; eneg_d = 1'b0; pesc_d = 1'b0; wm_d = '0; fail_d = E_OK;
			sig_d = '0; fz_d = '0; em_d = '0;
		end
		if (bo.n != 3'd0) bo.r[bo.n[1:0] - 2'd1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; held_q <= '0; acc_q <= '0; ovf_q <= 1'b0; tokh_q <= 1'b0;
			fnz_q <= 1'b0; eneg_q <= 1'b0; pesc_q <= 1'b0; wm_q <= '0; fail_q <= E_OK;
			sig_q <= '0; fz_q <= '0; em_q <= '0;
		end else if (go) begin
			mode_q <= mode_d; held_q <= held_d; acc_q <= acc_d; ovf_q <= ovf_d; tokh_q <= tokh_d;
			fnz_q <= fnz_d; eneg_q <= eneg_d; pesc_q <= pesc_d; wm_q <= wm_d; fail_q <= fail_d;
			sig_q <= sig_d; fz_q <= fz_d; em_q <= em_d;
		end
	end

	assign b_valid = go && bo.n != 3'd0;
	assign b_data = bo;

	`ASSERT_NEVER(a_fail_idle, clk, arst_n, fail_q != E_OK && mode_q != M_IDLE, "scan after error")
	`ASSERT_IMPL(a_batch_size, clk, arst_n, b_valid |-> b_data.n <= 3'd4, "batch too large")
	`ASSERT_IMPL(a_le_out, clk, arst_n, (go && line_end) |-> b_valid, "line end gave no result")
endmodule

// ===== hw/rtl/ltok_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ltok_back import ltok_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic b_valid,
	input  batch_t b_data,
	output logic b_full,
	output logic valid,
	input  logic stall,
	output res_t res
);
	// Two-entry batch queue, then results are played out one a cycle while not stalled.
	batch_t q_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic [1:0] idx_q;
	logic pop, push;

	assign b_full = cnt_q == 2'd2;
	assign push = b_valid && !b_full;
	assign valid = cnt_q != 2'd0;
	assign res = q_q[rp_q].r[idx_q];
	assign pop = valid && !stall && ({1'b0, idx_q} + 3'd1 == q_q[rp_q].n);

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= b_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; wp_q <= 1'b0; rp_q <= 1'b0; idx_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) begin rp_q <= !rp_q; idx_q <= '0; end
			else if (valid && !stall) idx_q <= idx_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && cnt_q == 2'd2, "queue overflow")
	`ASSERT_IMPL(a_last_pop, clk, arst_n, (valid && !stall && res.last) |-> pop,
		"last result does not retire batch")
	`ASSERT_IMPL(a_hold, clk, arst_n, (valid && stall) |=> valid, "result dropped under stall")
endmodule
